// ===== hw/rtl/rabg_pkg.sv =====
`timescale 1ns / 1ps
// Package for the radial average bilinear grid block.
// Holds the sequencer state type, the angle count and the quarter sine table.
package rabg_pkg;

   localparam int ANGLE_COUNT = 180;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_SPLIT,
      ST_READ,
      ST_LERP,
      ST_DIFF,
      ST_ACC,
      ST_DIV,
      ST_DONE
   } state_type;

   localparam logic [15:0] QUARTER_SINE [0:90] = '{
      16'd0, 16'd572, 16'd1144, 16'd1715, 16'd2286, 16'd2856, 16'd3425, 16'd3993,
      16'd4560, 16'd5126, 16'd5690, 16'd6252, 16'd6813, 16'd7371, 16'd7927, 16'd8481,
      16'd9032, 16'd9580, 16'd10126, 16'd10668, 16'd11207, 16'd11743, 16'd12275,
      16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876, 16'd15384, 16'd15886,
      16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324, 16'd18795, 16'd19261,
      16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498, 16'd21926, 16'd22348,
      16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351, 16'd24730, 16'd25102,
      16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842, 16'd27166, 16'd27482,
      16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932, 16'd29197, 16'd29452,
      16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592, 16'd30792, 16'd30983,
      16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795, 16'd31928, 16'd32052,
      16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524, 16'd32588, 16'd32643,
      16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32767
   };

   // Q1.15 cosine of a whole degree, 0..179
   function automatic logic signed [15:0] trig_cos(input logic [7:0] deg);
      logic signed [15:0] res;
      if (deg <= 8'd90) res = QUARTER_SINE[7'(8'd90 - deg)];
      else res = -QUARTER_SINE[7'(deg - 8'd90)];
      return res;
   endfunction

   function automatic logic signed [15:0] trig_sin(input logic [7:0] deg);
      logic signed [15:0] res;
      if (deg <= 8'd90) res = QUARTER_SINE[7'(deg)];
      else res = QUARTER_SINE[7'(8'd180 - deg)];
      return res;
   endfunction

endpackage

// ===== hw/rtl/rabg_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module rabg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== hw/rtl/radial_average_bilinear_grid.sv =====
`timescale 1ns / 1ps
// Radial average over a bilinear grid. A write item is accepted and its result
// is valid in the next cycle; writes can follow back to back if responses are taken.
// A query steps per angle: multiply, split, four reads of the single grid RAM,
// y interpolation, difference, accumulate, for 180 angles; then divides by 180 and
// loads the result. No new item is taken before that. A sample outside the grid
// ends the query early. Synchronous reset initialises control state, the response,
// the sum and the configuration; datapath registers and the grid are undefined.
module radial_average_bilinear_grid #(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // row[5:0], col[11:6], value[27:12], radius[43:28]
   input  logic        req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // average
   output logic        rsp_tuser,   // ok
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import rabg_pkg::*;

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW = $clog2(DEPTH);
   localparam logic [6:0] COLS_RST = 7'((MAX_COLS < 64) ? MAX_COLS : 64);
   localparam logic [6:0] ROWS_RST = 7'((MAX_ROWS < 64) ? MAX_ROWS : 64);
   // n/180 = (n/4)/45, with 45 replaced by a reciprocal scaled by 2^27
   localparam logic [21:0] RECIP_45 = 22'd2982617;

   typedef struct packed {
      logic              fail;
      logic [6:0]        lo;
      logic [6:0]        hi;
      logic signed [16:0] frac;
   } coord_type;

   function automatic coord_type split_coord(input logic signed [49:0] q,
                                             input logic [6:0] lim);
      coord_type res;
      logic neg;
      logic [49:0] mag;
      logic [18:0] ip;
      logic exact;
      logic [19:0] hi;
      neg = q[49];
      mag = neg ? 50'(-q) : 50'(q);
      ip = mag[49:31];
      exact = (mag[30:0] == 31'd0);
      hi = 20'(ip) + 20'(!exact);
      res.fail = (neg && ip != 19'd0) || (hi >= 20'(lim));
      res.lo = ip[6:0];
      res.hi = hi[6:0];
      res.frac = neg ? -$signed({1'b0, mag[30:15]}) : $signed({1'b0, mag[30:15]});
      return res;
   endfunction

   // configuration
   logic [6:0]  grid_cols_ff, grid_rows_ff;
   logic [15:0] px_ff;
   logic [6:0]  cdim;

   assign csr_ready = 1'b1;

   always_comb begin
      cdim = csr_data[6:0];
      if (cdim < 7'd2) cdim = 7'd2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cols_ff <= COLS_RST;
         grid_rows_ff <= ROWS_RST;
         px_ff <= 16'd256;
      end else if (csr_valid) begin
         case (csr_index)
            2'd0: grid_cols_ff <= (32'(cdim) > MAX_COLS) ? COLS_RST : cdim;
            2'd1: grid_rows_ff <= (32'(cdim) > MAX_ROWS) ? ROWS_RST : cdim;
            2'd2: px_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // request fields
   logic [5:0]  req_row, req_col;
   logic [15:0] req_value, req_radius;
   assign req_row = req_tdata[5:0];
   assign req_col = req_tdata[11:6];
   assign req_value = req_tdata[27:12];
   assign req_radius = req_tdata[43:28];

   state_type state_ff, state_in;
   logic rsp_free, req_fire, wr_ok, rsp_load;
   logic [7:0] angle_ff;
   logic [2:0] rd_idx_ff;
   logic div_step_ff, div_done_ff;
   logic [31:0] p1_ff;
   logic signed [48:0] xprod_ff, yprod_ff;
   coord_type cx_ff, cy_ff, cx, cy;
   logic signed [15:0] v_ff [0:3];
   logic signed [34:0] vl_ff, vr_ff;
   logic signed [35:0] diff_ff;
   logic signed [63:0] sum_ff;
   logic [22:0] num_ff;
   logic [15:0] quo_ff;
   logic neg_ff;
   logic rsp_valid_ff, rsp_ok_ff;
   logic [15:0] rsp_avg_ff;

   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && rsp_free;
   assign req_fire = req_tvalid && req_tready;
   assign wr_ok = (32'(req_row) < MAX_ROWS) && (32'(req_col) < MAX_COLS);
   assign rsp_load = (req_fire && !req_tuser) || ((state_ff == ST_DONE) && rsp_free);

   // grid memory
   logic [AW-1:0] wr_addr, rd_addr;
   logic [15:0] rd_data;
   logic [6:0] rx, ry;

   assign wr_addr = AW'(AW'(req_row) * AW'(MAX_COLS) + AW'(req_col));

   always_comb begin
      case (rd_idx_ff)
         3'd0: begin ry = cy_ff.lo; rx = cx_ff.lo; end
         3'd1: begin ry = cy_ff.lo; rx = cx_ff.hi; end
         3'd2: begin ry = cy_ff.hi; rx = cx_ff.lo; end
         default: begin ry = cy_ff.hi; rx = cx_ff.hi; end
      endcase
   end
   assign rd_addr = AW'(AW'(ry) * AW'(MAX_COLS) + AW'(rx));

   rabg_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_grid (
      .clock   (clock),
      .wr_en   (req_fire && !req_tuser && wr_ok),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // coordinates
   logic signed [49:0] xq, yq;
   assign xq = $signed({1'b0, 6'(grid_cols_ff >> 1), 31'd0}) + 50'(xprod_ff);
   assign yq = $signed({1'b0, 6'(grid_rows_ff >> 1), 31'd0}) + 50'(yprod_ff);
   assign cx = split_coord(xq, grid_cols_ff);
   assign cy = split_coord(yq, grid_rows_ff);

   // division by 180
   logic [63:0] sum_mag;
   logic [42:0] quo_prod;
   assign sum_mag = sum_ff[63] ? 64'(-sum_ff) : 64'(sum_ff);
   assign quo_prod = 43'(num_ff[22:2]) * 43'(RECIP_45);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_fire && req_tuser) state_in = ST_MUL;
         ST_MUL:   state_in = ST_SPLIT;
         ST_SPLIT: state_in = (cx.fail || cy.fail) ? ST_DONE : ST_READ;
         ST_READ:  if (rd_idx_ff == 3'd4) state_in = ST_LERP;
         ST_LERP:  state_in = ST_DIFF;
         ST_DIFF:  state_in = ST_ACC;
         ST_ACC:   state_in = (angle_ff == 8'(ANGLE_COUNT - 1)) ? ST_DIV : ST_MUL;
         ST_DIV:   if (div_step_ff) state_in = ST_DONE;
         ST_DONE:  if (rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rsp_ok_ff <= 1'b0;
         rsp_avg_ff <= 16'd0;
         angle_ff <= 8'd0;
         rd_idx_ff <= 3'd0;
         div_step_ff <= 1'b0;
         div_done_ff <= 1'b0;
         sum_ff <= 64'sd0;
         neg_ff <= 1'b0;
      end else begin
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tvalid && rsp_tready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  p1_ff <= 32'(req_radius) * 32'(px_ff);
                  angle_ff <= 8'd0;
                  sum_ff <= 64'sd0;
                  if (!req_tuser) begin
                     rsp_ok_ff <= wr_ok;
                     rsp_avg_ff <= 16'd0;
                  end
               end
            end
            ST_MUL: begin
               xprod_ff <= 49'($signed({1'b0, p1_ff}) * trig_cos(angle_ff));
               yprod_ff <= 49'($signed({1'b0, p1_ff}) * trig_sin(angle_ff));
            end
            ST_SPLIT: begin
               cx_ff <= cx;
               cy_ff <= cy;
               rd_idx_ff <= 3'd0;
               div_done_ff <= 1'b0;
            end
            ST_READ: begin
               rd_idx_ff <= rd_idx_ff + 3'd1;
               if (rd_idx_ff != 3'd0) v_ff[2'(rd_idx_ff - 3'd1)] <= rd_data;
            end
            ST_LERP: begin
               vl_ff <= 35'($signed({v_ff[0], 16'd0}))
                      + 35'((17'(v_ff[2]) - 17'(v_ff[0])) * cy_ff.frac);
               vr_ff <= 35'($signed({v_ff[1], 16'd0}))
                      + 35'((17'(v_ff[3]) - 17'(v_ff[1])) * cy_ff.frac);
            end
            ST_DIFF: diff_ff <= 36'(vr_ff) - 36'(vl_ff);
            ST_ACC: begin
               sum_ff <= sum_ff + 64'($signed({vl_ff, 16'd0}))
                       + 64'(diff_ff * cx_ff.frac);
               angle_ff <= angle_ff + 8'd1;
               div_step_ff <= 1'b0;
            end
            ST_DIV: begin
               if (!div_step_ff) begin
                  num_ff <= (sum_mag[63:55] != 9'd0) ? 23'h7FFFFF : sum_mag[54:32];
                  neg_ff <= sum_ff[63];
                  div_step_ff <= 1'b1;
               end else begin
                  quo_ff <= quo_prod[42:27];
                  div_done_ff <= 1'b1;
               end
            end
            ST_DONE: begin
               if (rsp_free) begin
                  rsp_ok_ff <= div_done_ff;
                  if (!div_done_ff) rsp_avg_ff <= 16'd0;
                  else if (neg_ff) rsp_avg_ff <= (quo_ff > 16'd32768) ? 16'h8000
                                                 : 16'(-quo_ff);
                  else rsp_avg_ff <= (quo_ff > 16'd32767) ? 16'h7FFF : quo_ff;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = rsp_ok_ff;
   assign rsp_tdata = rsp_avg_ff;

endmodule
